>>> design/qoi_enc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the hash function of the QOI pixel encoder.
package qoi_enc_pkg;

    // Coordinate counters and configuration widths
    localparam int COORD_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CMP_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

    // Colour index
    localparam int INDEX_ENTRIES = 64;
    localparam int HASH_BITS     = $clog2(INDEX_ENTRIES);

    // Run length limit and chunk sizes
    localparam int RUN_BITS  = 6;
    localparam int RUN_LIMIT = 62;
    localparam int MAX_BYTES = 6;
    localparam int BCNT_BITS = $clog2(MAX_BYTES + 1);

    // Chunk queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Chunk tags
    localparam logic [7:0] OP_DIFF = 8'h40;
    localparam logic [7:0] OP_LUMA = 8'h80;
    localparam logic [7:0] OP_RUN  = 8'hC0;
    localparam logic [7:0] OP_RGB  = 8'hFE;
    localparam logic [7:0] OP_RGBA = 8'hFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ALPHA_MODE   = 2'd2
    } cfg_reg_e_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    // One pixel's worth of output bytes, byte 0 first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [BCNT_BITS-1:0]      count;
        logic                      done;
    } chunk_t;

    // Index position of a pixel: (r*3 + g*5 + b*7 + a*11) mod 64
    function automatic logic [HASH_BITS-1:0] qoi_hash(input pixel_t p);
        logic [12:0] sum;
        sum = 13'(p.r) * 13'd3 + 13'(p.g) * 13'd5 + 13'(p.b) * 13'd7 + 13'(p.a) * 13'd11;
        return sum[HASH_BITS-1:0];
    endfunction

endpackage

>>> design/qoi_enc_front.sv
`timescale 1ns / 1ps
// Front part: pixel stage, colour index, run and coordinate tracking, chunk selection.
module qoi_enc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  qoi_enc_pkg::pixel_t                 pix,
    input  logic [qoi_enc_pkg::CFG_BITS-1:0]    image_width,
    input  logic [qoi_enc_pkg::CFG_BITS-1:0]    image_height,
    input  logic                                q_full,
    output logic                                q_push,
    output qoi_enc_pkg::chunk_t                 q_entry
);

    localparam int CB    = qoi_enc_pkg::COORD_BITS;
    localparam int HB    = qoi_enc_pkg::HASH_BITS;
    localparam int CMP_W = qoi_enc_pkg::CMP_BITS;

    // Stage register and index read data
    logic                       a_valid_reg;
    qoi_enc_pkg::pixel_t        a_pix_reg;
    logic [HB-1:0]              a_hash_reg;
    logic [31:0]                mem_rd_reg;
    logic                       rd_valid_reg;
    logic                       byp_hit_reg;
    qoi_enc_pkg::pixel_t        byp_pix_reg;

    // Encoder state
    qoi_enc_pkg::pixel_t        prev_reg, prev_next;
    logic [qoi_enc_pkg::RUN_BITS-1:0] run_reg, run_next;
    logic [CB-1:0]              col_reg, col_next;
    logic [CB-1:0]              row_reg, row_next;
    logic                       fin_reg, fin_next;
    logic [qoi_enc_pkg::INDEX_ENTRIES-1:0] valid_reg;
    logic [31:0]                idx_mem [qoi_enc_pkg::INDEX_ENTRIES];

    logic                       accept;
    logic                       a_adv;
    logic                       work;
    logic [HB-1:0]              hash_in;
    logic                       wr_en;

    logic [CB-1:0]              col_inc;
    logic                       eol;
    logic                       last;
    logic                       same;
    logic [qoi_enc_pkg::RUN_BITS-1:0] run_inc;
    qoi_enc_pkg::pixel_t        idx_ent;
    logic [7:0]                 dr, dg, db;
    logic signed [8:0]          dr9, dg9, db9, vgr, vgb;
    logic                       is_small, is_luma;
    logic [qoi_enc_pkg::MAX_BYTES-1:0][7:0] c;
    logic [qoi_enc_pkg::BCNT_BITS-1:0] cl;
    logic                       have_run;
    logic [7:0]                 flush_byte;

    // Handshake: the stage frees up whenever the queue has room
    assign a_adv     = a_valid_reg && !q_full;
    assign pix_ready = !a_valid_reg || !q_full;
    assign accept    = pix_valid && pix_ready;
    assign work      = a_adv && !fin_reg;
    assign hash_in   = qoi_enc_pkg::qoi_hash(pix);
    assign wr_en     = work && !same;

    // Pixel stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    // Capture the pixel and forward an index write landing on the same edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg    <= pix;
            a_hash_reg   <= hash_in;
            rd_valid_reg <= valid_reg[hash_in];
            byp_hit_reg  <= wr_en && (a_hash_reg == hash_in);
            byp_pix_reg  <= a_pix_reg;
        end
    end

    // Colour index memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            idx_mem[a_hash_reg] <= a_pix_reg;
        end
        if (accept) begin
            mem_rd_reg <= idx_mem[hash_in];
        end
    end

    // Index entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[a_hash_reg] <= 1'b1;
        end
    end

    // Encoder state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'hFF};
            run_reg  <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            fin_reg  <= 1'b0;
        end else begin
            prev_reg <= prev_next;
            run_reg  <= run_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            fin_reg  <= fin_next;
        end
    end

    // Coordinates and end of image
    always_comb begin
        col_inc = col_reg + CB'(1);
        eol     = CMP_W'(col_inc) >= CMP_W'(image_width);
        col_next = col_reg;
        row_next = row_reg;
        if (work) begin
            col_next = eol ? '0 : col_inc;
            row_next = eol ? row_reg + CB'(1) : row_reg;
        end
        last = (CMP_W'(eol ? row_reg + CB'(1) : row_reg)) >= CMP_W'(image_height);
    end

    // Differences to the previous pixel
    always_comb begin
        idx_ent = byp_hit_reg ? byp_pix_reg : (rd_valid_reg ? mem_rd_reg : '0);
        same    = a_pix_reg == prev_reg;
        run_inc = run_reg + 6'd1;
        dr  = a_pix_reg.r - prev_reg.r;
        dg  = a_pix_reg.g - prev_reg.g;
        db  = a_pix_reg.b - prev_reg.b;
        dr9 = {dr[7], dr};
        dg9 = {dg[7], dg};
        db9 = {db[7], db};
        vgr = dr9 - dg9;
        vgb = db9 - dg9;
        is_small = dr9 >= -9'sd2 && dr9 <= 9'sd1 && dg9 >= -9'sd2 && dg9 <= 9'sd1 &&
                   db9 >= -9'sd2 && db9 <= 9'sd1;
        is_luma  = dg9 >= -9'sd32 && dg9 <= 9'sd31 && vgr >= -9'sd8 && vgr <= 9'sd7 &&
                   vgb >= -9'sd8 && vgb <= 9'sd7;
    end

    // Pick the chunk for a changed pixel
    always_comb begin
        c  = '0;
        cl = '0;
        if (idx_ent == a_pix_reg) begin
            c[0] = {2'b00, a_hash_reg};
            cl   = 3'd1;
        end else if (prev_reg.a == a_pix_reg.a) begin
            if (is_small) begin
                c[0] = qoi_enc_pkg::OP_DIFF |
                       {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2};
                cl   = 3'd1;
            end else if (is_luma) begin
                c[0] = qoi_enc_pkg::OP_LUMA | {2'b00, dg[5:0] + 6'd32};
                c[1] = {vgr[3:0] + 4'd8, vgb[3:0] + 4'd8};
                cl   = 3'd2;
            end else begin
                c[0] = qoi_enc_pkg::OP_RGB;
                c[1] = a_pix_reg.r;
                c[2] = a_pix_reg.g;
                c[3] = a_pix_reg.b;
                cl   = 3'd4;
            end
        end else begin
            c[0] = qoi_enc_pkg::OP_RGBA;
            c[1] = a_pix_reg.r;
            c[2] = a_pix_reg.g;
            c[3] = a_pix_reg.b;
            c[4] = a_pix_reg.a;
            cl   = 3'd5;
        end
    end

    // Assemble the queue entry and next state
    always_comb begin
        have_run   = run_reg != '0;
        flush_byte = qoi_enc_pkg::OP_RUN | {2'b00, run_reg - 6'd1};
        q_entry      = '0;
        q_entry.done = last;
        q_push       = 1'b0;
        prev_next    = prev_reg;
        run_next     = run_reg;
        fin_next     = fin_reg;
        if (work) begin
            prev_next = a_pix_reg;
            fin_next  = last;
            if (same) begin
                // Extend the run; flush at the limit or at image end
                q_entry.data[0] = qoi_enc_pkg::OP_RUN | {2'b00, run_reg};
                q_entry.count   = 3'd1;
                if (run_inc == 6'(qoi_enc_pkg::RUN_LIMIT) || last) begin
                    q_push   = 1'b1;
                    run_next = '0;
                end else begin
                    run_next = run_inc;
                end
            end else begin
                // Flush a pending run ahead of the chunk
                q_push   = 1'b1;
                run_next = '0;
                q_entry.data[0] = have_run ? flush_byte : c[0];
                for (int i = 1; i < qoi_enc_pkg::MAX_BYTES; i++) begin
                    q_entry.data[i] = have_run ? c[i-1] : c[i];
                end
                q_entry.count = cl + {2'b00, have_run};
            end
        end
    end

    // Checks
    a_run_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg < 6'(qoi_enc_pkg::RUN_LIMIT))
        else $error("run count reached the limit without a flush");

    a_no_write_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> !wr_en && !q_push)
        else $error("pixel encoded after the image ended");

endmodule

>>> design/qoi_enc_fifo.sv
`timescale 1ns / 1ps
// Short chunk queue between the front and back parts.
module qoi_enc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  qoi_enc_pkg::chunk_t  push_entry,
    output logic                 full,
    input  logic                 pop,
    output qoi_enc_pkg::chunk_t  head,
    output logic                 empty
);

    qoi_enc_pkg::chunk_t                 slot_reg [qoi_enc_pkg::QUEUE_DEPTH];
    logic [qoi_enc_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [qoi_enc_pkg::QCNT_BITS-1:0]   cnt_reg;

    assign full  = cnt_reg == qoi_enc_pkg::QCNT_BITS'(qoi_enc_pkg::QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + qoi_enc_pkg::QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + qoi_enc_pkg::QPTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + qoi_enc_pkg::QCNT_BITS'(1);
                2'b01:   cnt_reg <= cnt_reg - qoi_enc_pkg::QCNT_BITS'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("chunk queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("chunk queue underflow");

endmodule

>>> design/qoi_enc_back.sv
`timescale 1ns / 1ps
// Back part: walks the bytes of each queued chunk into the output register.
module qoi_enc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qoi_enc_pkg::chunk_t  head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    logic [qoi_enc_pkg::BCNT_BITS-1:0] ptr_reg;
    logic                              m_valid_reg;
    logic [7:0]                        m_data_reg;
    logic                              m_last_reg;
    logic                              m_user_reg;
    logic                              load;
    logic                              end_byte;

    assign load     = !empty && (!m_valid_reg || m_tready);
    assign end_byte = ptr_reg == head.count - 3'd1;
    assign pop      = load && end_byte;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Byte pointer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                ptr_reg <= end_byte ? '0 : ptr_reg + 3'd1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= head.data[ptr_reg];
            m_last_reg <= end_byte;
            m_user_reg <= head.done;
        end
    end

    // Checks
    a_ptr_in_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (head.count != '0) && (ptr_reg < head.count))
        else $error("byte pointer outside the chunk");

endmodule

>>> design/qoi_pixel_encoder_top.sv
`timescale 1ns / 1ps
// Top level of the QOI pixel encoder: configuration registers and the three parts.
//
// Usage: pixels arrive on the s_ stream, one per beat, s_tdata = {alpha, blue, green,
// red} with red in the low byte. Encoded chunk bytes leave on the m_ stream, one per
// beat; m_tlast marks the final byte caused by a pixel and m_tuser is set on every
// byte caused by the image's last pixel. Runs produce no byte until they are flushed.
// Write image_width (index 0), image_height (index 1) and alpha_mode (index 2) through
// the cfg_ port while the block is idle; the 14-byte header and 8-byte end marker are
// software's job. After the last pixel further pixels are taken and dropped until reset.
// Bytes pass the pixel stage, a queue slot and the output register. Throughput: one
// pixel per cycle while each pixel yields at most one byte and m_tready stays high; a
// longer chunk holds the output for one beat per byte, and a four-entry chunk queue
// absorbs bursts before s_tready drops. The output byte port sets this rate. Reset
// (aresetn low, synchronous) clears the previous pixel, run, coordinates and the
// colour index valid bits; no clearing sweep is needed. When the receiver stalls, the
// output beat holds, the queue fills and then the input is back-pressured.
module qoi_pixel_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic        m_tuser,   // image_done[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [qoi_enc_pkg::CFG_BITS-1:0] width_reg;
    logic [qoi_enc_pkg::CFG_BITS-1:0] height_reg;
    logic                             mode_reg;
    qoi_enc_pkg::pixel_t              pix;
    logic                             q_push, q_full, q_pop, q_empty;
    qoi_enc_pkg::chunk_t              q_entry, q_head;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            mode_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                qoi_enc_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                qoi_enc_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                qoi_enc_pkg::CFG_ALPHA_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Unpack the pixel; force alpha opaque in three-channel mode
    always_comb begin
        pix.r = s_tdata[7:0];
        pix.g = s_tdata[15:8];
        pix.b = s_tdata[23:16];
        pix.a = mode_reg ? s_tdata[31:24] : 8'hFF;
    end

    qoi_enc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pix_valid    (s_tvalid),
        .pix_ready    (s_tready),
        .pix          (pix),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    qoi_enc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    qoi_enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
